// ----- src/gesd_pkg.sv -----
package gesd_pkg;

	// axis scaling
	localparam int AXIS_FULL_SCALE = 65535;
	localparam int RAW_MAX = 255;
	localparam int AXIS_W = 16;
	localparam logic [AXIS_W-1:0] AXIS_CENTER = AXIS_W'((AXIS_FULL_SCALE + 1) / 2);
	localparam int AXIS_COUNT = 4;

	// event kinds
	localparam logic [1:0] ACT_KEY = 2'd0;
	localparam logic [1:0] ACT_ABS = 2'd1;

	// event codes
	localparam logic [9:0] KEY_FIRST = 10'h120;
	localparam int KEY_COUNT = 12;
	localparam logic [9:0] ABS_X = 10'h000;
	localparam logic [9:0] ABS_Y = 10'h001;
	localparam logic [9:0] ABS_Z = 10'h002;
	localparam logic [9:0] ABS_RZ = 10'h005;
	localparam logic [9:0] ABS_HAT_X = 10'h010;
	localparam logic [9:0] ABS_HAT_Y = 10'h011;

	// hat position, two's complement
	localparam logic [1:0] HAT_NEG = 2'b11;
	localparam logic [1:0] HAT_ZERO = 2'b00;
	localparam logic [1:0] HAT_POS = 2'b01;

	// pov angles in hundredths of a degree
	localparam logic [14:0] POV_UP = 15'd0;
	localparam logic [14:0] POV_UP_RIGHT = 15'd4500;
	localparam logic [14:0] POV_RIGHT = 15'd9000;
	localparam logic [14:0] POV_DOWN_RIGHT = 15'd13500;
	localparam logic [14:0] POV_DOWN = 15'd18000;
	localparam logic [14:0] POV_DOWN_LEFT = 15'd22500;
	localparam logic [14:0] POV_LEFT = 15'd27000;
	localparam logic [14:0] POV_UP_LEFT = 15'd31500;

	typedef logic [AXIS_W-1:0] axis_lut_t [RAW_MAX+1];

	// deadzone and rescale for every clamped raw position
	function automatic axis_lut_t build_axis_lut();
		axis_lut_t lut;
		longint d;
		longint n;
		for (int c = 0; c <= RAW_MAX; c++) begin
			d = (2 * c > RAW_MAX) ? longint'(2 * c - RAW_MAX) : longint'(RAW_MAX - 2 * c);
			if (10 * d <= RAW_MAX) begin
				lut[c] = AXIS_CENTER;
			end else begin
				if (2 * c > RAW_MAX) begin
					n = 2295 + (10 * d - 255);
				end else begin
					n = 2295 - (10 * d - 255);
				end
				lut[c] = AXIS_W'((2 * n * longint'(AXIS_FULL_SCALE) + 4590) / 9180);
			end
		end
		return lut;
	endfunction

	localparam axis_lut_t AXIS_LUT = build_axis_lut();

endpackage

// ----- src/gesd_event_if.sv -----
interface gesd_event_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [9:0] code;
	logic signed [31:0] value;

	modport source (output valid, action, code, value, input ready);
	modport sink (input valid, action, code, value, output ready);
endinterface

// ----- src/gesd_snap_if.sv -----
interface gesd_snap_if;
	logic valid;
	logic ready;
	logic [11:0] buttons;
	logic [15:0] axis_x;
	logic [15:0] axis_y;
	logic [15:0] axis_z;
	logic [15:0] axis_r;
	logic pov_centered;
	logic [14:0] pov_angle;

	modport source (output valid, buttons, axis_x, axis_y, axis_z, axis_r, pov_centered,
		pov_angle, input ready);
	modport sink (input valid, buttons, axis_x, axis_y, axis_z, axis_r, pov_centered,
		pov_angle, output ready);
endinterface

// ----- src/gamepad_event_state_decoder.sv -----
// port   dir  word
// ev     in   action, code, value
// snap   out  buttons, axis_x..axis_r, pov_centered, pov_angle
//
// one word per cycle unless snap stalls; each word reaches snap via the result register
// an input register feeds the decode and state update, a result register holds the snapshot
// reset clears the buttons and hat and sets all axes to the center value
// while snap stalls, the input register still takes one word, then ev.ready drops
module gamepad_event_state_decoder (
	input logic clk,
	input logic arst_n,
	gesd_event_if.sink ev,
	gesd_snap_if.source snap
);

	// input register
	logic s1_valid_q;
	logic [1:0] action_s1;
	logic [9:0] code_s1;
	logic [31:0] value_s1;

	// decoder state
	logic [11:0] button_q;
	logic [gesd_pkg::AXIS_W-1:0] axis_q [gesd_pkg::AXIS_COUNT];
	logic [1:0] hat_h_q;
	logic [1:0] hat_v_q;

	// result register
	logic out_valid_q;
	logic [11:0] buttons_q;
	logic [gesd_pkg::AXIS_W-1:0] axis_out_q [gesd_pkg::AXIS_COUNT];
	logic centered_q;
	logic [14:0] angle_q;

	logic advance;
	logic [11:0] button_d;
	logic [gesd_pkg::AXIS_W-1:0] axis_d [gesd_pkg::AXIS_COUNT];
	logic [1:0] hat_h_d;
	logic [1:0] hat_v_d;
	logic [7:0] raw_clamp;
	logic [gesd_pkg::AXIS_W-1:0] axis_scaled;
	logic [1:0] hat_in;
	logic [9:0] key_off;
	logic key_hit;
	logic centered_d;
	logic [14:0] angle_d;

	assign advance = s1_valid_q && (!out_valid_q || snap.ready);
	assign ev.ready = !s1_valid_q || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (ev.ready) begin
			s1_valid_q <= ev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.ready && ev.valid) begin
			action_s1 <= ev.action;
			code_s1 <= ev.code;
			value_s1 <= ev.value;
		end
	end

	// clamp raw axis to 0..255 and scale through the table
	always_comb begin
		if (value_s1[31]) begin
			raw_clamp = 8'd0;
		end else if (|value_s1[30:8]) begin
			raw_clamp = 8'hFF;
		end else begin
			raw_clamp = value_s1[7:0];
		end
		axis_scaled = gesd_pkg::AXIS_LUT[raw_clamp];
	end

	// hat saturates to -1..1
	always_comb begin
		if (value_s1[31]) begin
			hat_in = gesd_pkg::HAT_NEG;
		end else if (value_s1 == 32'd0) begin
			hat_in = gesd_pkg::HAT_ZERO;
		end else begin
			hat_in = gesd_pkg::HAT_POS;
		end
	end

	assign key_off = code_s1 - gesd_pkg::KEY_FIRST;
	assign key_hit = (code_s1 >= gesd_pkg::KEY_FIRST)
		&& (key_off < 10'(gesd_pkg::KEY_COUNT));

	// next state
	always_comb begin
		button_d = button_q;
		axis_d = axis_q;
		hat_h_d = hat_h_q;
		hat_v_d = hat_v_q;
		if (action_s1 == gesd_pkg::ACT_KEY) begin
			if (key_hit) begin
				button_d[key_off[3:0]] = (value_s1 != 32'd0);
			end
		end else if (action_s1 == gesd_pkg::ACT_ABS) begin
			case (code_s1)
				gesd_pkg::ABS_X: axis_d[0] = axis_scaled;
				gesd_pkg::ABS_Y: axis_d[1] = axis_scaled;
				gesd_pkg::ABS_Z: axis_d[2] = axis_scaled;
				gesd_pkg::ABS_RZ: axis_d[3] = axis_scaled;
				gesd_pkg::ABS_HAT_X: hat_h_d = hat_in;
				gesd_pkg::ABS_HAT_Y: hat_v_d = hat_in;
				default: ;
			endcase
		end
	end

	// hat to pov angle
	always_comb begin
		centered_d = 1'b0;
		angle_d = gesd_pkg::POV_UP;
		if (hat_v_d == gesd_pkg::HAT_NEG) begin
			if (hat_h_d == gesd_pkg::HAT_POS) begin
				angle_d = gesd_pkg::POV_UP_RIGHT;
			end else if (hat_h_d == gesd_pkg::HAT_NEG) begin
				angle_d = gesd_pkg::POV_UP_LEFT;
			end else begin
				angle_d = gesd_pkg::POV_UP;
			end
		end else if (hat_v_d == gesd_pkg::HAT_POS) begin
			if (hat_h_d == gesd_pkg::HAT_POS) begin
				angle_d = gesd_pkg::POV_DOWN_RIGHT;
			end else if (hat_h_d == gesd_pkg::HAT_NEG) begin
				angle_d = gesd_pkg::POV_DOWN_LEFT;
			end else begin
				angle_d = gesd_pkg::POV_DOWN;
			end
		end else if (hat_h_d == gesd_pkg::HAT_POS) begin
			angle_d = gesd_pkg::POV_RIGHT;
		end else if (hat_h_d == gesd_pkg::HAT_NEG) begin
			angle_d = gesd_pkg::POV_LEFT;
		end else begin
			centered_d = 1'b1;
		end
	end

	// state update and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_q <= '0;
			for (int i = 0; i < gesd_pkg::AXIS_COUNT; i++) begin
				axis_q[i] <= gesd_pkg::AXIS_CENTER;
			end
			hat_h_q <= gesd_pkg::HAT_ZERO;
			hat_v_q <= gesd_pkg::HAT_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				button_q <= button_d;
				axis_q <= axis_d;
				hat_h_q <= hat_h_d;
				hat_v_q <= hat_v_d;
				out_valid_q <= 1'b1;
			end else if (snap.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			buttons_q <= button_d;
			axis_out_q <= axis_d;
			centered_q <= centered_d;
			angle_q <= angle_d;
		end
	end

	assign snap.valid = out_valid_q;
	assign snap.buttons = buttons_q;
	assign snap.axis_x = axis_out_q[0];
	assign snap.axis_y = axis_out_q[1];
	assign snap.axis_z = axis_out_q[2];
	assign snap.axis_r = axis_out_q[3];
	assign snap.pov_centered = centered_q;
	assign snap.pov_angle = angle_q;

`ifndef SYNTHESIS
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(button_q) && $stable(hat_h_q) && $stable(hat_v_q))
		else $error("decoder state changed without a word advancing");

	a_hat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hat_h_q != 2'b10 && hat_v_q != 2'b10)
		else $error("hat position outside -1..1");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && snap.valid && !snap.ready |-> !ev.ready)
		else $error("input taken while both registers are full");

	a_centered_angle: assert property (@(posedge clk) disable iff (!arst_n)
		snap.valid && snap.pov_centered |-> snap.pov_angle == gesd_pkg::POV_UP)
		else $error("centered hat with nonzero angle");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> snap.valid && snap.buttons == $past(button_d))
		else $error("snapshot does not follow the advanced word");
`endif

endmodule

// ----- dv/testbench.sv -----
module testbench;

	// ignored event kinds
	localparam logic [1:0] ACT_OTHER = 2'd2;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// codes that decode to nothing
	localparam logic [9:0] ABS_UNUSED = 10'h003;
	localparam logic [9:0] CODE_TOP = 10'h3FF;

	localparam logic [9:0] ABS_CODES [6] = '{gesd_pkg::ABS_X, gesd_pkg::ABS_Y,
		gesd_pkg::ABS_Z, gesd_pkg::ABS_RZ, gesd_pkg::ABS_HAT_X, gesd_pkg::ABS_HAT_Y};

	localparam int RANDOM_WORDS = 475;
	localparam int CALM_TAIL = 80;
	localparam int LONG_HOLD = 60;
	localparam int HOLD_AT = 150;
	localparam int DRAIN_AT = 300;
	localparam int IDLE_LIMIT = 1000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [1:0] action;
		logic [9:0] code;
		logic [31:0] value;
	} event_word_t;

	typedef struct {
		event_word_t word;
		bit drain_first;
		bit calm;
	} pending_t;

	typedef struct packed {
		logic [11:0] buttons;
		logic [15:0] axis_x;
		logic [15:0] axis_y;
		logic [15:0] axis_z;
		logic [15:0] axis_r;
		logic pov_centered;
		logic [14:0] pov_angle;
	} snapshot_t;

	logic clk = 1'b0;
	logic arst_n;

	gesd_event_if ev_bus ();
	gesd_snap_if snap_bus ();

	gamepad_event_state_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.ev(ev_bus),
		.snap(snap_bus)
	);

	// predicted pad state
	logic [11:0] btn_state;
	logic [15:0] axis_state [gesd_pkg::AXIS_COUNT];
	logic [1:0] hat_h;
	logic [1:0] hat_v;

	pending_t events_pending [$];
	snapshot_t snapshots_due [$];
	pending_t head;

	int sent_count = 0;
	int results_seen = 0;
	int total_words = 0;
	int error_count = 0;
	int send_gap = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int idle_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// clamp to 0..255, deadzone, then rescale to full scale
	function automatic logic [15:0] scaled_position(logic [31:0] raw);
		longint c;
		longint span;
		longint num;
		if (raw[31]) begin
			c = 0;
		end else if (raw > 32'd255) begin
			c = 255;
		end else begin
			c = raw;
		end
		span = (2 * c > 255) ? 2 * c - 255 : 255 - 2 * c;
		if (10 * span <= 255) begin
			return 16'((gesd_pkg::AXIS_FULL_SCALE + 1) / 2);
		end
		if (2 * c > 255) begin
			num = 2295 + (10 * span - 255);
		end else begin
			num = 2295 - (10 * span - 255);
		end
		return 16'((2 * num * longint'(gesd_pkg::AXIS_FULL_SCALE) + 4590) / 9180);
	endfunction

	function automatic logic [1:0] hat_level(logic [31:0] raw);
		if (raw[31]) begin
			return gesd_pkg::HAT_NEG;
		end
		return (raw == 32'd0) ? gesd_pkg::HAT_ZERO : gesd_pkg::HAT_POS;
	endfunction

	// update the predicted state with one event and return its snapshot
	function automatic snapshot_t decode_event(logic [1:0] action, logic [9:0] code,
		logic [31:0] value);
		snapshot_t snap;
		if (action == gesd_pkg::ACT_KEY) begin
			if (code >= gesd_pkg::KEY_FIRST
				&& code < gesd_pkg::KEY_FIRST + gesd_pkg::KEY_COUNT) begin
				btn_state[int'(code - gesd_pkg::KEY_FIRST)] = (value != 32'd0);
			end
		end else if (action == gesd_pkg::ACT_ABS) begin
			case (code)
				gesd_pkg::ABS_X: axis_state[0] = scaled_position(value);
				gesd_pkg::ABS_Y: axis_state[1] = scaled_position(value);
				gesd_pkg::ABS_Z: axis_state[2] = scaled_position(value);
				gesd_pkg::ABS_RZ: axis_state[3] = scaled_position(value);
				gesd_pkg::ABS_HAT_X: hat_h = hat_level(value);
				gesd_pkg::ABS_HAT_Y: hat_v = hat_level(value);
				default: ;
			endcase
		end
		snap.buttons = btn_state;
		snap.axis_x = axis_state[0];
		snap.axis_y = axis_state[1];
		snap.axis_z = axis_state[2];
		snap.axis_r = axis_state[3];
		snap.pov_centered = 1'b0;
		if (hat_v == gesd_pkg::HAT_NEG) begin
			snap.pov_angle = (hat_h == gesd_pkg::HAT_ZERO) ? gesd_pkg::POV_UP :
				(hat_h == gesd_pkg::HAT_POS) ? gesd_pkg::POV_UP_RIGHT : gesd_pkg::POV_UP_LEFT;
		end else if (hat_v == gesd_pkg::HAT_POS) begin
			snap.pov_angle = (hat_h == gesd_pkg::HAT_ZERO) ? gesd_pkg::POV_DOWN :
				(hat_h == gesd_pkg::HAT_POS) ? gesd_pkg::POV_DOWN_RIGHT :
				gesd_pkg::POV_DOWN_LEFT;
		end else if (hat_h == gesd_pkg::HAT_POS) begin
			snap.pov_angle = gesd_pkg::POV_RIGHT;
		end else if (hat_h == gesd_pkg::HAT_NEG) begin
			snap.pov_angle = gesd_pkg::POV_LEFT;
		end else begin
			snap.pov_centered = 1'b1;
			snap.pov_angle = '0;
		end
		return snap;
	endfunction

	function automatic void queue_word(logic [1:0] action, logic [9:0] code, logic [31:0] value);
		pending_t item;
		item.word.action = action;
		item.word.code = code;
		item.word.value = value;
		item.drain_first = 1'b0;
		item.calm = 1'b0;
		events_pending.push_back(item);
	endfunction

	function automatic logic [31:0] axis_raw_value();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 255));
			1: return 32'($urandom_range(105, 150));
			2: return 32'($urandom_range(240, 270));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] hat_raw_value();
		case ($urandom_range(0, 3))
			0: return 32'hFFFF_FFFF;
			1: return 32'd0;
			2: return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	// mostly well-formed events with random content, the rest noise
	function automatic void queue_random_word();
		int sel;
		int pick;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			queue_word(gesd_pkg::ACT_KEY,
				gesd_pkg::KEY_FIRST + 10'($urandom_range(0, gesd_pkg::KEY_COUNT - 1)),
				$urandom_range(0, 1) ? 32'd0 : $urandom);
		end else if (sel < 8) begin
			pick = $urandom_range(0, 5);
			queue_word(gesd_pkg::ACT_ABS, ABS_CODES[pick],
				(pick >= 4) ? hat_raw_value() : axis_raw_value());
		end else begin
			queue_word(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)), $urandom);
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	function automatic void head_check(snapshot_t want);
		check_field("buttons", want.buttons, snap_bus.buttons);
		check_field("axis_x", want.axis_x, snap_bus.axis_x);
		check_field("axis_y", want.axis_y, snap_bus.axis_y);
		check_field("axis_z", want.axis_z, snap_bus.axis_z);
		check_field("axis_r", want.axis_r, snap_bus.axis_r);
		check_field("pov_centered", want.pov_centered, snap_bus.pov_centered);
		check_field("pov_angle", want.pov_angle, snap_bus.pov_angle);
	endfunction

	// event driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_bus.valid <= 1'b0;
			ev_bus.action <= '0;
			ev_bus.code <= '0;
			ev_bus.value <= '0;
			send_gap = 0;
		end else begin
			// predict the snapshot of the word taken at this edge
			if (ev_bus.valid && ev_bus.ready) begin
				snapshots_due.push_back(decode_event(ev_bus.action, ev_bus.code, ev_bus.value));
				sent_count++;
			end
			// offer a new word once the current one is gone
			if (!ev_bus.valid || ev_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					ev_bus.valid <= 1'b0;
				end else if (events_pending.size() == 0) begin
					ev_bus.valid <= 1'b0;
				end else if (events_pending[0].drain_first && snapshots_due.size() != 0) begin
					ev_bus.valid <= 1'b0;
				end else if (!events_pending[0].calm && (sent_count / 64) % 3 != 2 &&
					$urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 10);
					ev_bus.valid <= 1'b0;
				end else begin
					head = events_pending.pop_front();
					ev_bus.valid <= 1'b1;
					ev_bus.action <= head.word.action;
					ev_bus.code <= head.word.code;
					ev_bus.value <= head.word.value;
				end
			end
		end
	end

	// snapshot ready, with random stalls and one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_bus.ready <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			snap_bus.ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= HOLD_AT) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			snap_bus.ready <= 1'b0;
		end else if (results_seen < total_words - CALM_TAIL && (results_seen / 64) % 3 != 1 &&
			$urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(0, 10);
			snap_bus.ready <= 1'b0;
		end else begin
			snap_bus.ready <= 1'b1;
		end
	end

	// compare every snapshot word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && snap_bus.valid && snap_bus.ready) begin
			results_seen++;
			if (snapshots_due.size() == 0) begin
				$display("%0t: unexpected snapshot, expected none, got buttons %h", $time,
					snap_bus.buttons);
				error_count++;
			end else begin
				head_check(snapshots_due.pop_front());
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((ev_bus.valid && ev_bus.ready) || (snap_bus.valid && snap_bus.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		// state after reset
		btn_state = '0;
		foreach (axis_state[i]) begin
			axis_state[i] = 16'((gesd_pkg::AXIS_FULL_SCALE + 1) / 2);
		end
		hat_h = gesd_pkg::HAT_ZERO;
		hat_v = gesd_pkg::HAT_ZERO;

		// buttons, including the edges of the key range and codes just outside it
		queue_word(gesd_pkg::ACT_KEY, gesd_pkg::KEY_FIRST, 32'd1);
		queue_word(gesd_pkg::ACT_KEY, gesd_pkg::KEY_FIRST + 10'd11, 32'h8000_0000);
		queue_word(gesd_pkg::ACT_KEY, gesd_pkg::KEY_FIRST + 10'd5, 32'h7FFF_FFFF);
		queue_word(gesd_pkg::ACT_KEY, gesd_pkg::KEY_FIRST, 32'd0);
		queue_word(gesd_pkg::ACT_KEY, gesd_pkg::KEY_FIRST - 10'd1, 32'd1);
		queue_word(gesd_pkg::ACT_KEY, gesd_pkg::KEY_FIRST + 10'd12, 32'd1);
		// axis extremes, clamping and the deadzone edges
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_X, 32'd0);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_Y, 32'd255);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_Z, 32'h8000_0000);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_RZ, 32'h7FFF_FFFF);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_X, 32'd114);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_X, 32'd115);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_Y, 32'd140);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_Y, 32'd141);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_Z, 32'd256);
		queue_word(gesd_pkg::ACT_ABS, ABS_UNUSED, 32'd200);
		queue_word(gesd_pkg::ACT_ABS, CODE_TOP, 32'd0);
		// hat with saturation, walking through several directions back to center
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_HAT_X, 32'd1);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_HAT_Y, 32'hFFFF_FFFB);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_HAT_X, 32'h8000_0000);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_HAT_Y, 32'd7);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_HAT_X, 32'd0);
		queue_word(gesd_pkg::ACT_ABS, gesd_pkg::ABS_HAT_Y, 32'd0);
		// ignored event kinds
		queue_word(ACT_OTHER, gesd_pkg::KEY_FIRST, 32'd1);
		queue_word(ACT_SPARE, CODE_TOP, 32'hFFFF_FFFF);

		repeat (RANDOM_WORDS) begin
			queue_random_word();
		end
		events_pending[DRAIN_AT].drain_first = 1'b1;
		for (int i = events_pending.size() - CALM_TAIL; i < events_pending.size(); i++) begin
			events_pending[i].calm = 1'b1;
		end
		total_words = events_pending.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every word to go in and every snapshot to come out
		while (sent_count < total_words || snapshots_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
